@@ design/pdisp_pkg.sv @@
// Shared types and codes for the process dispatcher.
// Holds the ready-queue entry layout, policy, operation and register codes,
// their reset values and the head-read kinds. No dependencies.
package pdisp_pkg;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] need;
        logic [15:0] used;
    } entry_t;

    localparam logic       OP_ENQUEUE = 1'b0;
    localparam logic       OP_TICK    = 1'b1;

    localparam logic [1:0] MODE_FCFS  = 2'd0;
    localparam logic [1:0] MODE_SPF   = 2'd1;
    localparam logic [1:0] MODE_RR    = 2'd2;

    localparam logic       REG_POLICY_MODE  = 1'b0;
    localparam logic       REG_TIME_QUANTUM = 1'b1;

    localparam logic [1:0] POLICY_RESET  = MODE_FCFS;
    localparam logic [7:0] QUANTUM_RESET = 8'd2;

    // What a head read feeds once its data is back
    localparam logic [1:0] POP_START   = 2'd0;
    localparam logic [1:0] POP_PREEMPT = 2'd1;
    localparam logic [1:0] POP_DONE    = 2'd2;

endpackage

@@ design/process_dispatcher_fcfs_spf_rr.sv @@
// Process dispatcher top level: ready queue in a circular memory plus a sequencer.
// Depends on pdisp_pkg (entry layout and codes).
//
// Takes enqueue and tick words and returns one result word per input word.
// The ready queue is a circular buffer in a single memory with one write port
// and one registered read port; every queue access goes through that port under
// a small sequencer, and the block takes no new word until the current one is
// finished and its result is in the output register. A refused enqueue, or a
// tick with nothing ready, goes straight to the response; a plain enqueue
// (FCFS or RR) first writes its entry at the tail. A shortest-need enqueue
// walks the queue from the head to find its slot and then moves the later
// entries back one at a time, a read and a write per entry moved, before it
// writes its own entry. A tick that runs a process reads the head first for
// a first dispatch or an RR preemption, then adds one to the runner's used
// count; on completion it reads the head again to load the next runner. The
// response waits while the previous result word is still in the output register.
// After reset there is no clearing pass; only data from occupied slots is ever used.
module process_dispatcher_fcfs_spf_rr #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  proc_id,
    input  logic [15:0] need_units,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        enqueue_refused,
    output logic        ran_valid,
    output logic [7:0]  ran_id,
    output logic        done_valid,
    output logic [7:0]  done_id,
    output logic [4:0]  queue_count
);
    import pdisp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_SHIFT_RD = 4'd3;
    localparam logic [3:0] S_SHIFT_WR = 4'd4;
    localparam logic [3:0] S_INSERT   = 4'd5;
    localparam logic [3:0] S_POP      = 4'd6;
    localparam logic [3:0] S_GIVE     = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    // Logical queue position to memory slot
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(pos);
        if (s >= SUM_W'(QUEUE_DEPTH))
            s = s - SUM_W'(QUEUE_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    entry_t queue_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [7:0]       quantum_reg, quantum_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             run_valid_reg, run_valid_next;
    entry_t           run_entry_reg, run_entry_next;
    logic [7:0]       slice_reg, slice_next;
    logic [7:0]       item_id_reg, item_id_next;
    logic [15:0]      item_need_reg, item_need_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       pop_kind_reg, pop_kind_next;
    logic             res_refused_reg, res_refused_next;
    logic             res_ran_reg, res_ran_next;
    logic [7:0]       res_ran_id_reg, res_ran_id_next;
    logic             res_done_reg, res_done_next;
    logic [7:0]       res_done_id_reg, res_done_id_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_refused_reg, out_refused_next;
    logic             out_ran_reg, out_ran_next;
    logic [7:0]       out_ran_id_reg, out_ran_id_next;
    logic             out_done_reg, out_done_next;
    logic [7:0]       out_done_id_reg, out_done_id_next;
    logic [4:0]       out_count_reg, out_count_next;

    logic [PTR_W-1:0] mem_raddr;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [7:0]       quantum_eff;
    logic             slice_left;
    logic [15:0]      used_inc;
    logic [PTR_W-1:0] head_inc;

    assign quantum_eff = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign slice_left  = slice_reg < quantum_eff;
    assign used_inc    = run_entry_reg.used + 16'd1;
    assign head_inc    = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        quantum_next     = quantum_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        run_valid_next   = run_valid_reg;
        run_entry_next   = run_entry_reg;
        slice_next       = slice_reg;
        item_id_next     = item_id_reg;
        item_need_next   = item_need_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        pop_kind_next    = pop_kind_reg;
        res_refused_next = res_refused_reg;
        res_ran_next     = res_ran_reg;
        res_ran_id_next  = res_ran_id_reg;
        res_done_next    = res_done_reg;
        res_done_id_next = res_done_id_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_refused_next = out_refused_reg;
        out_ran_next     = out_ran_reg;
        out_ran_id_next  = out_ran_id_reg;
        out_done_next    = out_done_reg;
        out_done_id_next = out_done_id_reg;
        out_count_next   = out_count_reg;
        mem_raddr        = head_reg;
        mem_we           = 1'b0;
        mem_waddr        = head_reg;
        mem_wdata        = run_entry_reg;

        if (cfg_we)
        begin
            if (cfg_index == REG_POLICY_MODE)
                mode_next = cfg_data[1:0];
            else
                quantum_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_id_next     = proc_id;
                    item_need_next   = need_units;
                    res_refused_next = 1'b0;
                    res_ran_next     = 1'b0;
                    res_ran_id_next  = '0;
                    res_done_next    = 1'b0;
                    res_done_id_next = '0;
                    if (operation == OP_ENQUEUE)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            res_refused_next = 1'b1;
                            state_next       = S_RESP;
                        end
                        else if (mode_reg == MODE_SPF)
                        begin
                            pos_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            state_next = S_INSERT;
                        end
                    end
                    else if (mode_reg == MODE_RR && run_valid_reg && !slice_left)
                    begin
                        // Quantum used up: rotate, or rerun alone with a fresh slice
                        slice_next = '0;
                        if (count_reg != '0)
                        begin
                            pop_kind_next = POP_PREEMPT;
                            state_next    = S_POP;
                        end
                        else
                            state_next = S_GIVE;
                    end
                    else if (run_valid_reg)
                        state_next = S_GIVE;
                    else if (count_reg != '0)
                    begin
                        pop_kind_next = POP_START;
                        state_next    = S_POP;
                    end
                    else
                        state_next = S_RESP;
                end
            end

            S_SCAN_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    mem_raddr  = phys(head_reg, pos_reg);
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (rd_data_reg.need <= item_need_reg)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                    state_next = S_INSERT;
                else
                begin
                    mem_raddr  = phys(head_reg, idx_reg - CNT_W'(1));
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, idx_reg);
                mem_wdata  = rd_data_reg;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_SHIFT_RD;
            end

            S_INSERT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, pos_reg);
                mem_wdata  = '{id: item_id_reg, need: item_need_reg, used: 16'd0};
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_POP:
            begin
                run_entry_next = rd_data_reg;
                run_valid_next = 1'b1;
                head_next      = head_inc;
                case (pop_kind_reg)
                    POP_PREEMPT:
                    begin
                        // Old runner takes the tail slot; the head was read first
                        mem_we     = 1'b1;
                        mem_waddr  = phys(head_reg, count_reg);
                        mem_wdata  = run_entry_reg;
                        state_next = S_GIVE;
                    end
                    POP_DONE:
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        count_next = count_reg - CNT_W'(1);
                        slice_next = '0;
                        state_next = S_GIVE;
                    end
                endcase
            end

            S_GIVE:
            begin
                run_entry_next.used = used_inc;
                slice_next          = slice_reg + 8'd1;
                res_ran_next        = 1'b1;
                res_ran_id_next     = run_entry_reg.id;
                state_next          = S_RESP;
                if (used_inc >= run_entry_reg.need)
                begin
                    res_done_next    = 1'b1;
                    res_done_id_next = run_entry_reg.id;
                    run_valid_next   = 1'b0;
                    slice_next       = '0;
                    if (count_reg != '0)
                    begin
                        pop_kind_next = POP_DONE;
                        state_next    = S_POP;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_refused_next = res_refused_reg;
                    out_ran_next     = res_ran_reg;
                    out_ran_id_next  = res_ran_id_reg;
                    out_done_next    = res_done_reg;
                    out_done_id_next = res_done_id_reg;
                    out_count_next   = 5'(count_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            queue_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= queue_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= POLICY_RESET;
            quantum_reg   <= QUANTUM_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_entry_reg <= '0;
            slice_reg     <= '0;
            pop_kind_reg  <= POP_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            quantum_reg   <= quantum_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_entry_reg <= run_entry_next;
            slice_reg     <= slice_next;
            pop_kind_reg  <= pop_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_id_reg     <= item_id_next;
        item_need_reg   <= item_need_next;
        pos_reg         <= pos_next;
        idx_reg         <= idx_next;
        res_refused_reg <= res_refused_next;
        res_ran_reg     <= res_ran_next;
        res_ran_id_reg  <= res_ran_id_next;
        res_done_reg    <= res_done_next;
        res_done_id_reg <= res_done_id_next;
        out_refused_reg <= out_refused_next;
        out_ran_reg     <= out_ran_next;
        out_ran_id_reg  <= out_ran_id_next;
        out_done_reg    <= out_done_next;
        out_done_id_reg <= out_done_id_next;
        out_count_reg   <= out_count_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign enqueue_refused = out_refused_reg;
    assign ran_valid       = out_ran_reg;
    assign ran_id          = out_ran_id_reg;
    assign done_valid      = out_done_reg;
    assign done_id         = out_done_id_reg;
    assign queue_count     = out_count_reg;

endmodule

@@ design/pdisp_checker.sv @@
// Port-level checks for the process dispatcher, attached by bind.
// Depends on the top level's port list only.
module pdisp_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        cfg_index,
    input logic [7:0]  cfg_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic        operation,
    input logic [7:0]  proc_id,
    input logic [15:0] need_units,
    input logic        out_valid,
    input logic        out_ready,
    input logic        enqueue_refused,
    input logic        ran_valid,
    input logic [7:0]  ran_id,
    input logic        done_valid,
    input logic [7:0]  done_id,
    input logic [4:0]  queue_count
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ran_id) && $stable(done_id)
            && $stable(queue_count) && $stable(enqueue_refused))
        else $error("result word changed while stalled");

    a_refused_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enqueue_refused |-> !ran_valid && !done_valid)
        else $error("refused enqueue reports a run or completion");

    a_done_is_runner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_valid |-> ran_valid && done_id == ran_id)
        else $error("completion does not match the process that ran");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (QUEUE_DEPTH > 31) || (int'(queue_count) <= QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // Drop ready in the cycle after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind process_dispatcher_fcfs_spf_rr pdisp_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pdisp_checker (.*);
